>>> rtl/core/cafb_pkg.sv
// ----------------------------------------------------------------------------
// cafb_pkg
// Shared types and constants for the reader command frame builder: request
// and result structs, the decoded command that passes from front to back,
// opcodes, status codes and the fixed frame bytes.
// ----------------------------------------------------------------------------
`default_nettype none

package cafb_pkg;

  // Request opcodes.
  localparam logic [2:0] OP_START   = 3'd0;
  localparam logic [2:0] OP_DATA    = 3'd1;
  localparam logic [2:0] OP_ACK     = 3'd2;
  localparam logic [2:0] OP_PWR_ON  = 3'd3;
  localparam logic [2:0] OP_PWR_OFF = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_LONG  = 2'd1;
  localparam logic [1:0] ST_STRAY = 2'd2;
  localparam logic [1:0] ST_OPEN  = 2'd3;

  // Fixed frame bytes.
  localparam logic [7:0] STX_BYTE     = 8'h02;
  localparam logic [7:0] ETX_BYTE     = 8'h03;
  localparam logic [7:0] XFR_TYPE     = 8'h6F;
  localparam logic [7:0] PWR_ON_TYPE  = 8'h62;
  localparam logic [7:0] PWR_OFF_TYPE = 8'h63;
  localparam logic [7:0] DIR_PREFIX   = 8'hD4;
  localparam logic [7:0] APDU_CLASS   = 8'hFF;
  localparam logic [7:0] MAX_DLEN     = 8'hFF;

  // Depth of the queue between front and back.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] payload_length;
    logic       add_prefix;
    logic [7:0] apdu_p1;
    logic [7:0] apdu_p2;
    logic [7:0] payload_byte;
  } cafb_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic       frame_done;
    logic [1:0] status;
  } cafb_res_t;

  typedef enum logic [1:0] {
    KIND_STATUS,
    KIND_APDU,
    KIND_POWER,
    KIND_DATA
  } cafb_kind_t;

  // Decoded command: everything the back end needs to expand one request.
  typedef struct packed {
    cafb_kind_t kind;
    logic [1:0] status;
    logic       tail;
    logic       prefix;
    logic [7:0] seq;
    logic [7:0] p1;
    logic [7:0] p2;
    logic [7:0] dlen;
    logic [7:0] data;
  } cafb_cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/cafb_front.sv
// ----------------------------------------------------------------------------
// cafb_front
// Accepts requests, checks them against the frame state and turns each one
// that produces output into a decoded command for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cafb_front import cafb_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      accept,
  input  wire cafb_req_t req,
  output logic           push,
  output cafb_cmd_t      cmd
);

  logic [7:0] next_seq_r, next_seq_nxt;
  logic [7:0] sent_seq_r, sent_seq_nxt;
  logic [7:0] remaining_r, remaining_nxt;
  logic       open_r, open_nxt;
  logic       emits;
  logic [7:0] dlen;

  assign dlen = req.payload_length + {7'd0, req.add_prefix};

  // Classify the request and work out the next frame state.
  always_comb begin
    emits         = 1'b0;
    next_seq_nxt  = next_seq_r;
    sent_seq_nxt  = sent_seq_r;
    remaining_nxt = remaining_r;
    open_nxt      = open_r;
    cmd           = '{kind: KIND_STATUS, status: ST_OK, tail: 1'b0, prefix: 1'b0,
                      seq: next_seq_r, p1: req.apdu_p1, p2: req.apdu_p2,
                      dlen: dlen, data: req.payload_byte};
    case (req.op)
      OP_START: begin
        emits = 1'b1;
        if (open_r) begin
          cmd.status = ST_OPEN;
        end else if (req.payload_length == MAX_DLEN && req.add_prefix) begin
          cmd.status = ST_LONG;
        end else begin
          cmd.kind      = KIND_APDU;
          cmd.tail      = (req.payload_length == 8'd0);
          cmd.prefix    = req.add_prefix;
          sent_seq_nxt  = next_seq_r;
          remaining_nxt = req.payload_length;
          open_nxt      = (req.payload_length != 8'd0);
        end
      end
      OP_DATA: begin
        emits = 1'b1;
        if (!open_r) begin
          cmd.status = ST_STRAY;
        end else begin
          cmd.kind      = KIND_DATA;
          cmd.tail      = (remaining_r == 8'd1);
          remaining_nxt = remaining_r - 8'd1;
          open_nxt      = (remaining_r != 8'd1);
        end
      end
      OP_ACK: begin
        next_seq_nxt = sent_seq_r + 8'd1;
      end
      OP_PWR_ON, OP_PWR_OFF: begin
        emits = 1'b1;
        if (open_r) begin
          cmd.status = ST_OPEN;
        end else begin
          cmd.kind     = KIND_POWER;
          cmd.tail     = 1'b1;
          cmd.data     = (req.op == OP_PWR_ON) ? PWR_ON_TYPE : PWR_OFF_TYPE;
          sent_seq_nxt = 8'd0;
        end
      end
      default: begin
        emits = 1'b0;
      end
    endcase
  end

  assign push = accept && emits;

  // Frame state commits only on an accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_seq_r  <= 8'd0;
      sent_seq_r  <= 8'd0;
      remaining_r <= 8'd0;
      open_r      <= 1'b0;
    end else if (accept) begin
      next_seq_r  <= next_seq_nxt;
      sent_seq_r  <= sent_seq_nxt;
      remaining_r <= remaining_nxt;
      open_r      <= open_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/cafb_queue.sv
// ----------------------------------------------------------------------------
// cafb_queue
// Small command queue between front and back so that each side can stall
// without holding up the other.
// ----------------------------------------------------------------------------
`default_nettype none

module cafb_queue import cafb_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire cafb_cmd_t push_cmd,
  input  wire logic      pop,
  output cafb_cmd_t      head_cmd,
  output logic           not_empty,
  output logic           full
);

  cafb_cmd_t          mem_r [QDEPTH];
  logic [QAW-1:0]     wr_ptr_r;
  logic [QAW-1:0]     rd_ptr_r;
  logic [QAW:0]       count_r, count_nxt;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == (QAW+1)'(QDEPTH));
  assign head_cmd  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (QAW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QAW+1)'(1);
    end
  end

  // Storage needs no reset; only the pointers and fill count do.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/cafb_back.sv
// ----------------------------------------------------------------------------
// cafb_back
// Expands the head command into frame bytes or a status result, one per
// unstalled cycle, keeps the running checksum and holds the registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module cafb_back import cafb_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cafb_cmd_t head_cmd,
  input  wire logic      not_empty,
  output logic           pop,
  output logic           out_valid,
  input  wire logic      out_stall,
  output cafb_res_t      out_res
);

  // Positions within the transfer and APDU headers.
  localparam logic [4:0] IDX_TYPE   = 5'd1;
  localparam logic [4:0] IDX_LEN_LO = 5'd2;
  localparam logic [4:0] IDX_LEN_HI = 5'd3;
  localparam logic [4:0] IDX_SEQ    = 5'd7;
  localparam logic [4:0] IDX_CLASS  = 5'd11;
  localparam logic [4:0] IDX_P1     = 5'd13;
  localparam logic [4:0] IDX_P2     = 5'd14;
  localparam logic [4:0] IDX_DLEN   = 5'd15;
  localparam logic [4:0] IDX_PREFIX = 5'd16;
  localparam logic [4:0] APDU_BODY  = 5'd15;
  localparam logic [4:0] POWER_BODY = 5'd10;

  logic [4:0] idx_r;
  logic [7:0] xor_r, xor_nxt;
  logic       out_valid_r;
  cafb_res_t  out_res_r, res_nxt;
  logic       advance;
  logic       load;
  logic [4:0] body_last;
  logic [4:0] final_idx;
  logic [8:0] total;
  logic [7:0] body_byte;

  assign advance   = !out_valid_r || !out_stall;
  assign load      = advance && not_empty;
  assign total     = 9'd5 + {1'b0, head_cmd.dlen};
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Index of the last checksummed byte, and of the final result.
  always_comb begin
    case (head_cmd.kind)
      KIND_APDU:  body_last = APDU_BODY + {4'd0, head_cmd.prefix};
      KIND_POWER: body_last = POWER_BODY;
      default:    body_last = 5'd0;
    endcase
    final_idx = (head_cmd.kind != KIND_STATUS && head_cmd.tail) ?
                body_last + 5'd2 : body_last;
  end

  // Header or payload byte at the current position.
  always_comb begin
    body_byte = 8'd0;
    case (head_cmd.kind)
      KIND_APDU: begin
        case (idx_r)
          IDX_TYPE:   body_byte = XFR_TYPE;
          IDX_LEN_LO: body_byte = total[7:0];
          IDX_LEN_HI: body_byte = {7'd0, total[8]};
          IDX_SEQ:    body_byte = head_cmd.seq;
          IDX_CLASS:  body_byte = APDU_CLASS;
          IDX_P1:     body_byte = head_cmd.p1;
          IDX_P2:     body_byte = head_cmd.p2;
          IDX_DLEN:   body_byte = head_cmd.dlen;
          IDX_PREFIX: body_byte = DIR_PREFIX;
          default:    body_byte = 8'd0;
        endcase
      end
      KIND_POWER: body_byte = (idx_r == IDX_TYPE) ? head_cmd.data : 8'd0;
      KIND_DATA:  body_byte = head_cmd.data;
      default:    body_byte = 8'd0;
    endcase
  end

  // Select the result and the checksum update for this position.
  always_comb begin
    xor_nxt = xor_r;
    res_nxt = '{out_byte: 8'd0, byte_valid: 1'b1, last: (idx_r == final_idx),
                frame_done: 1'b0, status: ST_OK};
    if (head_cmd.kind == KIND_STATUS) begin
      res_nxt.byte_valid = 1'b0;
      res_nxt.status     = head_cmd.status;
    end else if (idx_r == 5'd0 && head_cmd.kind != KIND_DATA) begin
      res_nxt.out_byte = STX_BYTE;
      xor_nxt          = 8'd0;
    end else if (idx_r <= body_last) begin
      res_nxt.out_byte = body_byte;
      xor_nxt          = xor_r ^ body_byte;
    end else if (idx_r == body_last + 5'd1) begin
      res_nxt.out_byte = xor_r;
    end else begin
      res_nxt.out_byte   = ETX_BYTE;
      res_nxt.frame_done = 1'b1;
    end
  end

  assign pop = load && (idx_r == final_idx);

  // Output register and sequencing counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 5'd0;
      xor_r       <= 8'd0;
    end else if (advance) begin
      out_valid_r <= not_empty;
      if (load) begin
        xor_r <= xor_nxt;
        idx_r <= pop ? 5'd0 : idx_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ccid_apdu_frame_builder_core.sv
// ----------------------------------------------------------------------------
// ccid_apdu_frame_builder_core
// Reader command frame builder: STX, transfer header, APDU header, payload,
// XOR checksum and ETX, serialised one byte per result.
//
//   Channel | Direction | Handshake              | Payload
//   in_     | input     | in_valid / in_stall    | in_req  (cafb_req_t)
//   out_    | output    | out_valid / out_stall  | out_res (cafb_res_t)
//
// A request is checked and decoded in the cycle it is accepted; decoded
// commands wait in a four-entry queue. The back end issues one result per
// cycle that the output is free: a payload request yields one result (three
// when it closes the frame), a start request up to 19 and a power request 13.
// in_stall rises only while the queue is full; output stalls hold the
// registered result. Reset clears the frame state, queue and output.
// ----------------------------------------------------------------------------
`default_nettype none

module ccid_apdu_frame_builder_core import cafb_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire cafb_req_t in_req,
  output logic           out_valid,
  input  wire logic      out_stall,
  output cafb_res_t      out_res
);

  logic      accept;
  logic      push;
  logic      pop;
  logic      not_empty;
  logic      full;
  cafb_cmd_t push_cmd;
  cafb_cmd_t head_cmd;

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  cafb_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .req    (in_req),
    .push   (push),
    .cmd    (push_cmd)
  );

  cafb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .head_cmd  (head_cmd),
    .not_empty (not_empty),
    .full      (full)
  );

  cafb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_cmd  (head_cmd),
    .not_empty (not_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

endmodule

`default_nettype wire

>>> rtl/core/cafb_checker.sv
// ----------------------------------------------------------------------------
// cafb_checker
// Port-level checks on the frame builder's request and result channels,
// bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module cafb_checker import cafb_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire cafb_req_t in_req,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire cafb_res_t out_res
);

  // A stalled request stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_req))
    else $error("request changed while stalled");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_res))
    else $error("result changed while stalled");

  // A status-only result carries an error code and ends its request.
  a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_res.byte_valid |-> out_res.last && out_res.status != ST_OK)
    else $error("malformed status result");

  // The closing byte is ETX and always the last result of its request.
  a_etx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.frame_done |->
      out_res.byte_valid && out_res.last && out_res.out_byte == ETX_BYTE)
    else $error("frame closed on a wrong byte");

  // Frame bytes never carry an error code.
  a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.byte_valid |-> out_res.status == ST_OK)
    else $error("frame byte with error status");

endmodule

bind ccid_apdu_frame_builder_core cafb_checker u_cafb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_res   (out_res)
);

`default_nettype wire

>>> sim/tb_ccid_apdu_frame_builder_core.sv
// ----------------------------------------------------------------------------
// tb_ccid_apdu_frame_builder_core
// Self-checking bench for the reader command frame builder. A table of
// directed requests covers the field extremes, every opcode and the error
// cases. Random request streams follow, made mostly of well-formed frames
// with noise mixed in. Each accepted request is expanded into the bytes and
// status results it should cause. Every result taken from the block is
// compared field by field with the oldest outstanding prediction. Requests
// idle and results stall at random, and there is one long output hold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ccid_apdu_frame_builder_core;
  import cafb_pkg::*;

  // Opcodes that the block ignores.
  localparam logic [2:0] OP_RSVD_LO  = 3'd5;
  localparam logic [2:0] OP_RSVD_MID = 3'd6;
  localparam logic [2:0] OP_RSVD_HI  = 3'd7;

  localparam logic [7:0] APDU_HDR_LEN = 8'd5;
  localparam int POWER_ZEROS  = 9;
  localparam int N_DIR        = 22;
  localparam int RAND_ITEMS   = 308;
  localparam int BIG_AT       = 24;
  localparam int RESET_CYCLES = 12;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AFTER   = N_DIR + 40;
  localparam int TAIL_CYCLES  = 40;
  // Worst case: every request gives 19 results that each wait out the longest
  // output stall, plus the gaps and the long hold.
  localparam int CYCLE_LIMIT  = 2_000_000;

  typedef struct {
    cafb_req_t req;
    bit        typed;
    cafb_res_t res;
    bit        drain;
  } stim_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  cafb_req_t in_req;
  logic      out_valid;
  logic      out_stall;
  cafb_res_t out_res;

  // Requests waiting to be sent, results still due, and the predictor's copy
  // of the frame state.
  stim_t     requests_to_send[$];
  cafb_res_t pending_results[$];
  cafb_res_t req_results[$];
  logic [7:0] seq_next;
  logic [7:0] seq_sent;
  logic [7:0] run_csum;
  logic [7:0] data_left;
  logic       frame_is_open;

  int  n_errors   = 0;
  int  n_accepted = 0;
  int  n_results  = 0;
  int  n_frames   = 0;
  int  n_status   = 0;
  int  n_cycles   = 0;
  int  hold_left  = 0;
  bit  hold_done  = 1'b0;
  bit  pause_next = 1'b0;

  ccid_apdu_frame_builder_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // One line per mismatch, and a running count.
  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    n_errors++;
  endtask

  function automatic int pick_idle(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic cafb_req_t rand_req(input logic [2:0] op);
    cafb_req_t r;
    r.op             = op;
    r.payload_length = 8'($urandom_range(0, 255));
    r.add_prefix     = 1'($urandom_range(0, 1));
    r.apdu_p1        = 8'($urandom_range(0, 255));
    r.apdu_p2        = 8'($urandom_range(0, 255));
    r.payload_byte   = 8'($urandom_range(0, 255));
    return r;
  endfunction

  function automatic stim_t dir_row(input logic [2:0] op, input logic [7:0] plen,
                                    input logic pre, input logic [7:0] p1,
                                    input logic [7:0] p2, input logic [7:0] pb,
                                    input bit typed, input logic [1:0] st);
    stim_t s;
    s.req.op             = op;
    s.req.payload_length = plen;
    s.req.add_prefix     = pre;
    s.req.apdu_p1        = p1;
    s.req.apdu_p2        = p2;
    s.req.payload_byte   = pb;
    s.typed              = typed;
    s.res.out_byte       = 8'h00;
    s.res.byte_valid     = 1'b0;
    s.res.last           = 1'b1;
    s.res.frame_done     = 1'b0;
    s.res.status         = st;
    s.drain              = 1'b0;
    return s;
  endfunction

  // Queue a random request; the first one after a pause marker waits for
  // every outstanding result before it is offered.
  function void queue_req(input cafb_req_t r);
    stim_t s;
    s.req      = r;
    s.typed    = 1'b0;
    s.res      = '0;
    s.drain    = pause_next;
    pause_next = 1'b0;
    requests_to_send.push_back(s);
  endfunction

  function void add_res(input logic [7:0] b, input logic bv, input logic done,
                        input logic [1:0] st);
    cafb_res_t r;
    r.out_byte   = b;
    r.byte_valid = bv;
    r.last       = 1'b0;
    r.frame_done = done;
    r.status     = st;
    req_results.push_back(r);
  endfunction

  // A frame byte that counts toward the checksum.
  function void add_body(input logic [7:0] b);
    run_csum = run_csum ^ b;
    add_res(b, 1'b1, 1'b0, ST_OK);
  endfunction

  function void add_tail();
    add_res(run_csum, 1'b1, 1'b0, ST_OK);
    add_res(ETX_BYTE, 1'b1, 1'b1, ST_OK);
    frame_is_open = 1'b0;
    data_left     = 8'd0;
  endfunction

  // Expand one accepted request into the results it causes.
  function void expand_request(input cafb_req_t r);
    logic [8:0]  dlen;
    logic [15:0] total;
    req_results.delete();
    dlen  = {1'b0, r.payload_length} + {8'd0, r.add_prefix};
    total = {8'd0, APDU_HDR_LEN} + {7'd0, dlen};
    case (r.op)
      OP_START: begin
        if (frame_is_open) begin
          add_res(8'h00, 1'b0, 1'b0, ST_OPEN);
        end else if (dlen > {1'b0, MAX_DLEN}) begin
          add_res(8'h00, 1'b0, 1'b0, ST_LONG);
        end else begin
          seq_sent = seq_next;
          run_csum = 8'h00;
          add_res(STX_BYTE, 1'b1, 1'b0, ST_OK);
          add_body(XFR_TYPE);
          add_body(total[7:0]);
          add_body(total[15:8]);
          add_body(8'h00);
          add_body(8'h00);
          add_body(8'h00);
          add_body(seq_sent);
          add_body(8'h00);
          add_body(8'h00);
          add_body(8'h00);
          add_body(APDU_CLASS);
          add_body(8'h00);
          add_body(r.apdu_p1);
          add_body(r.apdu_p2);
          add_body(dlen[7:0]);
          if (r.add_prefix) add_body(DIR_PREFIX);
          frame_is_open = 1'b1;
          data_left     = r.payload_length;
          if (r.payload_length == 8'd0) add_tail();
        end
      end
      OP_DATA: begin
        if (!frame_is_open) begin
          add_res(8'h00, 1'b0, 1'b0, ST_STRAY);
        end else begin
          add_body(r.payload_byte);
          data_left = data_left - 8'd1;
          if (data_left == 8'd0) add_tail();
        end
      end
      OP_ACK: begin
        seq_next = seq_sent + 8'd1;
      end
      OP_PWR_ON, OP_PWR_OFF: begin
        if (frame_is_open) begin
          add_res(8'h00, 1'b0, 1'b0, ST_OPEN);
        end else begin
          seq_sent = 8'h00;
          run_csum = 8'h00;
          add_res(STX_BYTE, 1'b1, 1'b0, ST_OK);
          add_body(r.op == OP_PWR_ON ? PWR_ON_TYPE : PWR_OFF_TYPE);
          for (int i = 0; i < POWER_ZEROS; i++) add_body(8'h00);
          add_tail();
        end
      end
      default: begin
      end
    endcase
    if (req_results.size() > 0) req_results[req_results.size() - 1].last = 1'b1;
  endfunction

  // Request side: offer requests with random gaps and predict each one as
  // it is accepted.
  initial begin : drive_requests
    stim_t cur;
    int    gap_left;
    bit    quiet;
    in_valid <= 1'b0;
    in_req   <= '0;
    gap_left = 0;
    quiet    = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (in_valid && !in_stall) begin
        expand_request(cur.req);
        if (cur.typed) begin
          pending_results.push_back(cur.res);
        end else begin
          foreach (req_results[i]) pending_results.push_back(req_results[i]);
        end
        n_accepted++;
      end
      if ($urandom_range(0, 29) == 0) quiet = !quiet;
      if (in_valid && in_stall) begin
        // Hold the stalled request as it is.
      end else if (gap_left > 0 && hold_left == 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (requests_to_send.size() == 0) begin
        in_valid <= 1'b0;
      end else if (requests_to_send[0].drain && pending_results.size() != 0) begin
        in_valid <= 1'b0;
      end else begin
        cur = requests_to_send.pop_front();
        in_req   <= cur.req;
        in_valid <= 1'b1;
        gap_left = pick_idle(quiet);
      end
    end
  end

  // Result side: check each result taken and choose the stall for the next
  // cycle, with one long hold so that the block backs up into its input.
  initial begin : drain_results
    cafb_res_t want;
    int        stall_left;
    bit        quiet;
    out_stall <= 1'b0;
    stall_left = 0;
    quiet      = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        n_results++;
        if (pending_results.size() == 0) begin
          report_mismatch("unpredicted result", 16'(out_res), 16'd0);
        end else begin
          want = pending_results.pop_front();
          if (out_res.out_byte !== want.out_byte)
            report_mismatch("out_byte", 16'(out_res.out_byte), 16'(want.out_byte));
          if (out_res.byte_valid !== want.byte_valid)
            report_mismatch("byte_valid", 16'(out_res.byte_valid), 16'(want.byte_valid));
          if (out_res.last !== want.last)
            report_mismatch("last", 16'(out_res.last), 16'(want.last));
          if (out_res.frame_done !== want.frame_done)
            report_mismatch("frame_done", 16'(out_res.frame_done), 16'(want.frame_done));
          if (out_res.status !== want.status)
            report_mismatch("status", 16'(out_res.status), 16'(want.status));
          if (want.frame_done) n_frames++;
          if (!want.byte_valid) n_status++;
        end
      end
      if ($urandom_range(0, 39) == 0) quiet = !quiet;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && n_accepted >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = pick_idle(quiet);
        out_stall <= (stall_left != 0);
        if (stall_left != 0) stall_left--;
      end
    end
  end

  // Cycle budget for the whole run.
  always @(posedge clk) begin : watchdog
    n_cycles++;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("[ccid_apdu_frame_builder_core] ERROR");
      $finish;
    end
  end

  // Build the stimulus, release reset and wait for the block to drain.
  initial begin : run_test
    stim_t     dir_tab [N_DIR];
    cafb_req_t r;
    int        counted;
    int        pick;
    int        plen;
    int        n_total;
    bit        big_done;

    rst_n <= 1'b0;
    seq_next      = 8'h00;
    seq_sent      = 8'h00;
    run_csum      = 8'h00;
    data_left     = 8'h00;
    frame_is_open = 1'b0;

    // Directed table; status-only rows carry their result, the rest go
    // through the predictor.
    dir_tab[0]  = dir_row(OP_DATA, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b1, ST_STRAY);
    dir_tab[1]  = dir_row(OP_ACK, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, ST_OK);
    dir_tab[2]  = dir_row(OP_START, 8'hFF, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b1, ST_LONG);
    dir_tab[3]  = dir_row(OP_START, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, ST_OK);
    dir_tab[4]  = dir_row(OP_ACK, 8'hFF, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b0, ST_OK);
    dir_tab[5]  = dir_row(OP_START, 8'h00, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b0, ST_OK);
    dir_tab[6]  = dir_row(OP_PWR_ON, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, ST_OK);
    dir_tab[7]  = dir_row(OP_ACK, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, ST_OK);
    dir_tab[8]  = dir_row(OP_PWR_OFF, 8'hFF, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b0, ST_OK);
    dir_tab[9]  = dir_row(OP_START, 8'h02, 1'b1, 8'hA5, 8'h5A, 8'h00, 1'b0, ST_OK);
    dir_tab[10] = dir_row(OP_START, 8'h01, 1'b0, 8'h00, 8'h00, 8'h00, 1'b1, ST_OPEN);
    dir_tab[11] = dir_row(OP_PWR_ON, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b1, ST_OPEN);
    dir_tab[12] = dir_row(OP_PWR_OFF, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b1, ST_OPEN);
    dir_tab[13] = dir_row(OP_ACK, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, ST_OK);
    dir_tab[14] = dir_row(OP_DATA, 8'h00, 1'b0, 8'h00, 8'h00, 8'hFF, 1'b0, ST_OK);
    dir_tab[15] = dir_row(OP_DATA, 8'hFF, 1'b1, 8'hFF, 8'hFF, 8'h00, 1'b0, ST_OK);
    dir_tab[16] = dir_row(OP_START, 8'h01, 1'b0, 8'h00, 8'hFF, 8'h00, 1'b0, ST_OK);
    dir_tab[17] = dir_row(OP_DATA, 8'h00, 1'b0, 8'h00, 8'h00, 8'h5A, 1'b0, ST_OK);
    dir_tab[18] = dir_row(OP_RSVD_LO, 8'hFF, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b0, ST_OK);
    dir_tab[19] = dir_row(OP_RSVD_MID, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, ST_OK);
    dir_tab[20] = dir_row(OP_RSVD_HI, 8'hAA, 1'b0, 8'h55, 8'hAA, 8'h55, 1'b0, ST_OK);
    dir_tab[21] = dir_row(OP_DATA, 8'h00, 1'b0, 8'h00, 8'h00, 8'hC3, 1'b1, ST_STRAY);
    for (int i = 0; i < N_DIR; i++) requests_to_send.push_back(dir_tab[i]);

    // Random part: mostly complete frames with random content, with acks,
    // power frames, errors and ignored opcodes in between. One frame carries
    // the longest payload so that the length field reaches its high byte.
    counted    = 0;
    big_done   = 1'b0;
    pause_next = 1'b1;
    while (counted < RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (!big_done && counted >= BIG_AT) begin
        big_done = 1'b1;
        r = rand_req(OP_START);
        r.add_prefix     = 1'($urandom_range(0, 1));
        r.payload_length = r.add_prefix ? 8'd254 : 8'd255;
        queue_req(r);
        for (int k = 0; k < int'(r.payload_length); k++) queue_req(rand_req(OP_DATA));
        counted += int'(r.payload_length) + 1;
        pause_next = 1'b1;
      end else if (pick < 55) begin
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
        r = rand_req(OP_START);
        r.payload_length = 8'(plen);
        queue_req(r);
        counted++;
        for (int k = 0; k < plen; k++) begin
          // Occasional noise inside an open frame.
          if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 4))
              0: queue_req(rand_req(OP_START));
              1: queue_req(rand_req(OP_PWR_ON));
              2: queue_req(rand_req(OP_PWR_OFF));
              3: queue_req(rand_req(OP_ACK));
              default: queue_req(rand_req(3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI))));
            endcase
            counted++;
          end
          queue_req(rand_req(OP_DATA));
          counted++;
        end
      end else if (pick < 65) begin
        queue_req(rand_req(OP_ACK));
        counted++;
      end else if (pick < 77) begin
        queue_req(rand_req($urandom_range(0, 1) ? OP_PWR_ON : OP_PWR_OFF));
        counted++;
      end else if (pick < 85) begin
        queue_req(rand_req(OP_DATA));
        counted++;
      end else if (pick < 91) begin
        r = rand_req(OP_START);
        r.payload_length = MAX_DLEN;
        r.add_prefix     = 1'b1;
        queue_req(r);
        counted++;
      end else begin
        queue_req(rand_req(3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI))));
        counted++;
      end
    end
    n_total = requests_to_send.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted < n_total) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", 16'(pending_results.size()), 16'd0);

    $display("Sent %0d requests (%0d from the directed table); checked %0d results.",
             n_total, N_DIR, n_results);
    $display("Seen %0d frames closed by ETX and %0d status-only results, with one %0d-cycle hold.",
             n_frames, n_status, LONG_HOLD);
    if (n_errors == 0) begin
      $display("[ccid_apdu_frame_builder_core] OK");
    end else begin
      $display("[ccid_apdu_frame_builder_core] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/cafb_pkg.sv
rtl/core/cafb_front.sv
rtl/core/cafb_queue.sv
rtl/core/cafb_back.sv
rtl/core/ccid_apdu_frame_builder_core.sv
rtl/core/cafb_checker.sv
sim/tb_ccid_apdu_frame_builder_core.sv
